@@ src/cdd_pkg.sv @@
// Package for the centered direct DFT block: frame size, field widths,
// controller/datapath command and status structs, and the twiddle wave lookup.
// Used by cdd_ctrl, cdd_datapath and centered_direct_dft_unit.
`default_nettype none

package cdd_pkg;

   localparam int POINTS      = 64;
   localparam int LOG2_POINTS = $clog2(POINTS);
   localparam int HALF_POINTS = POINTS / 2;

   localparam int SAMPLE_W  = 16;
   localparam int FRAC_BITS = 15;
   localparam int BIN_W     = 6;
   localparam int REAL_W    = 23;
   localparam int MAG_W     = 22;

   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int ACC_W    = PROD_W + LOG2_POINTS;
   localparam int RE_W     = ACC_W - FRAC_BITS;
   localparam int RAD_W    = 2 * (RE_W - 1);
   localparam int SQ_STEPS = RAD_W / 2;
   localparam int ROOT_CW  = $clog2(SQ_STEPS);

   localparam int WAVE_W       = 6;
   localparam int WAVE_QUARTER = 16;
   localparam int WAVE_SHIFT   = WAVE_W - LOG2_POINTS;

   typedef logic [LOG2_POINTS-1:0] idx_type;
   typedef logic [BIN_W-1:0]       bin_type;
   typedef logic [ROOT_CW-1:0]     root_cnt_type;
   typedef logic [WAVE_W-1:0]      wave_idx_type;

   typedef struct packed {
      logic    load_wr;
      logic    mac_issue;
      logic    clear_acc;
      logic    sq_re;
      logic    sq_im;
      logic    rad_load;
      logic    root_step;
      logic    out_load;
      idx_type addr;
      idx_type phase;
      bin_type bin_index;
      logic    last_bin;
   } cmd_type;

   typedef struct packed {
      logic mac_busy;
      logic out_free;
   } status_type;

   localparam logic [16:0] QUARTER_SINE [17] = '{
      17'd0,     17'd3212,  17'd6393,  17'd9512,  17'd12540, 17'd15447,
      17'd18205, 17'd20788, 17'd23170, 17'd25330, 17'd27246, 17'd28899,
      17'd30274, 17'd31357, 17'd32138, 17'd32610, 17'd32768
   };

   // Q1.15 sine of 2*pi*j/64, clamped to the 16-bit signed range.
   function automatic logic signed [SAMPLE_W-1:0] wave_sin(input wave_idx_type j);
      logic [1:0]         q;
      logic [4:0]         r;
      logic [4:0]         r_mirror;
      logic signed [17:0] v;
      q        = j[5:4];
      r        = {1'b0, j[3:0]};
      r_mirror = 5'(WAVE_QUARTER) - r;
      case (q)
         2'd0:    v = signed'({1'b0, QUARTER_SINE[r]});
         2'd1:    v = signed'({1'b0, QUARTER_SINE[r_mirror]});
         2'd2:    v = -signed'({1'b0, QUARTER_SINE[r]});
         2'd3:    v = -signed'({1'b0, QUARTER_SINE[r_mirror]});
         default: v = '0;
      endcase
      if (v > 18'sd32767) begin
         v = 18'sd32767;
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ src/cdd_ctrl.sv @@
// Controller of the centered direct DFT block: sample loading, the per-bin
// multiply-accumulate sweep, squaring, the root iterations and result hand-off.
// Depends on cdd_pkg for widths and the command and status structs.
`default_nettype none

module cdd_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  cdd_pkg::status_type status,
   output cdd_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_LOAD   = 7'b0000001,
      ST_MAC    = 7'b0000010,
      ST_DRAIN  = 7'b0000100,
      ST_SQ_IM  = 7'b0001000,
      ST_SQ_SUM = 7'b0010000,
      ST_ROOT   = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   cdd_pkg::idx_type      load_cnt_ff, load_cnt_in;
   cdd_pkg::idx_type      n_ff, n_in;
   cdd_pkg::idx_type      phase_ff, phase_in;
   cdd_pkg::idx_type      bin_ff, bin_in;
   cdd_pkg::root_cnt_type root_cnt_ff, root_cnt_in;
   cdd_pkg::idx_type      kmod;

   localparam cdd_pkg::idx_type LAST_IDX = cdd_pkg::idx_type'(cdd_pkg::POINTS - 1);
   localparam cdd_pkg::root_cnt_type LAST_ROOT =
      cdd_pkg::root_cnt_type'(cdd_pkg::SQ_STEPS - 1);

   assign kmod = bin_ff ^ cdd_pkg::idx_type'(cdd_pkg::HALF_POINTS);

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      n_in        = n_ff;
      phase_in    = phase_ff;
      bin_in      = bin_ff;
      root_cnt_in = root_cnt_ff;
      req_ready   = 1'b0;

      cmd           = '0;
      cmd.addr      = (state_ff == ST_LOAD) ? load_cnt_ff : n_ff;
      cmd.phase     = phase_ff;
      cmd.bin_index = cdd_pkg::bin_type'(bin_ff) -
                      cdd_pkg::bin_type'(cdd_pkg::HALF_POINTS);
      cmd.last_bin  = (bin_ff == LAST_IDX);

      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_wr = 1'b1;
               load_cnt_in = load_cnt_ff + 1'b1;
               if (load_cnt_ff == LAST_IDX) begin
                  load_cnt_in   = '0;
                  bin_in        = '0;
                  n_in          = '0;
                  phase_in      = '0;
                  cmd.clear_acc = 1'b1;
                  state_in      = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            n_in          = n_ff + 1'b1;
            phase_in      = phase_ff + kmod;
            if (n_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.mac_busy) begin
               cmd.sq_re = 1'b1;
               state_in  = ST_SQ_IM;
            end
         end
         ST_SQ_IM: begin
            cmd.sq_im = 1'b1;
            state_in  = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            cmd.rad_load = 1'b1;
            root_cnt_in  = '0;
            state_in     = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            root_cnt_in   = root_cnt_ff + 1'b1;
            if (root_cnt_ff == LAST_ROOT) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (bin_ff == LAST_IDX) begin
                  state_in = ST_LOAD;
               end else begin
                  bin_in        = bin_ff + 1'b1;
                  n_in          = '0;
                  phase_in      = '0;
                  cmd.clear_acc = 1'b1;
                  state_in      = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         n_ff        <= '0;
         phase_ff    <= '0;
         bin_ff      <= '0;
         root_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         n_ff        <= n_in;
         phase_ff    <= phase_in;
         bin_ff      <= bin_in;
         root_cnt_ff <= root_cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ src/cdd_datapath.sv @@
// Datapath of the centered direct DFT block: sample memory, twiddle lookup,
// pipelined multiply-accumulate, shared squarer, bit-serial root and output register.
// Depends on cdd_pkg; driven by the command struct from cdd_ctrl.
`default_nettype none

module cdd_datapath (
   input  wire                                clock,
   input  wire                                reset,
   input  cdd_pkg::cmd_type                   cmd,
   output cdd_pkg::status_type                status,
   input  wire signed [cdd_pkg::SAMPLE_W-1:0] req_sample,
   input  wire                                rsp_ready,
   output logic                               rsp_valid,
   output logic signed [cdd_pkg::BIN_W-1:0]   rsp_bin_index,
   output logic signed [cdd_pkg::REAL_W-1:0]  rsp_real_part,
   output logic signed [cdd_pkg::REAL_W-1:0]  rsp_imag_part,
   output logic        [cdd_pkg::MAG_W-1:0]   rsp_magnitude,
   output logic                               rsp_last_bin
);

   logic signed [cdd_pkg::SAMPLE_W-1:0] mem [cdd_pkg::POINTS];

   logic signed [cdd_pkg::SAMPLE_W-1:0] x_ff;
   logic signed [cdd_pkg::SAMPLE_W-1:0] cos_ff, cos_in;
   logic signed [cdd_pkg::SAMPLE_W-1:0] sin_ff, sin_in;
   logic                                v1_ff, v2_ff;
   logic signed [cdd_pkg::PROD_W-1:0]   prod_re_ff, prod_re_in;
   logic signed [cdd_pkg::PROD_W-1:0]   prod_im_ff, prod_im_in;
   logic signed [cdd_pkg::ACC_W-1:0]    acc_re_ff, acc_im_ff;
   cdd_pkg::wave_idx_type               wave_idx;

   logic signed [cdd_pkg::RE_W-1:0]     re, im, sq_op;
   logic signed [2*cdd_pkg::RE_W-1:0]   sq_prod;
   logic [cdd_pkg::RAD_W-1:0]           sq_ff, sum_ff;
   logic [cdd_pkg::RAD_W-1:0]           v_ff, res_ff, bit_ff;
   logic [cdd_pkg::RAD_W:0]             trial;
   logic                                rsp_valid_ff;
   logic signed [cdd_pkg::BIN_W-1:0]    rsp_bin_index_ff;
   logic signed [cdd_pkg::REAL_W-1:0]   rsp_real_part_ff;
   logic signed [cdd_pkg::REAL_W-1:0]   rsp_imag_part_ff;
   logic        [cdd_pkg::MAG_W-1:0]    rsp_magnitude_ff;
   logic                                rsp_last_bin_ff;

   // Twiddle lookup from the phase (n * k) mod POINTS.
   assign wave_idx = cdd_pkg::wave_idx_type'(cmd.phase) << cdd_pkg::WAVE_SHIFT;
   assign sin_in   = cdd_pkg::wave_sin(wave_idx);
   assign cos_in   = cdd_pkg::wave_sin(wave_idx +
                                       cdd_pkg::wave_idx_type'(cdd_pkg::WAVE_QUARTER));

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         mem[cmd.addr] <= req_sample;
      end
      if (cmd.mac_issue) begin
         x_ff   <= mem[cmd.addr];
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign prod_re_in = x_ff * cos_ff;
   assign prod_im_in = x_ff * sin_ff;

   always_ff @(posedge clock) begin
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      if (cmd.clear_acc) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (v2_ff) begin
         acc_re_ff <= acc_re_ff + cdd_pkg::ACC_W'(prod_re_ff);
         acc_im_ff <= acc_im_ff - cdd_pkg::ACC_W'(prod_im_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
      end
   end

   // An arithmetic shift right by the fraction width is the floor division.
   assign re      = acc_re_ff[cdd_pkg::ACC_W-1:cdd_pkg::FRAC_BITS];
   assign im      = acc_im_ff[cdd_pkg::ACC_W-1:cdd_pkg::FRAC_BITS];
   assign sq_op   = cmd.sq_re ? re : im;
   assign sq_prod = sq_op * sq_op;
   assign trial   = {1'b0, res_ff} + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (cmd.sq_re || cmd.sq_im) begin
         sq_ff <= sq_prod[cdd_pkg::RAD_W-1:0];
      end
      if (cmd.sq_im) begin
         sum_ff <= sq_ff;
      end
      if (cmd.rad_load) begin
         v_ff   <= sum_ff + sq_ff;
         res_ff <= '0;
         bit_ff <= cdd_pkg::RAD_W'(1) << (cdd_pkg::RAD_W - 2);
      end else if (cmd.root_step) begin
         if ({1'b0, v_ff} >= trial) begin
            v_ff   <= v_ff - trial[cdd_pkg::RAD_W-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_bin_index_ff <= cmd.bin_index;
         rsp_real_part_ff <= cdd_pkg::REAL_W'(re);
         rsp_imag_part_ff <= cdd_pkg::REAL_W'(im);
         rsp_magnitude_ff <= cdd_pkg::MAG_W'(res_ff[cdd_pkg::SQ_STEPS-1:0]);
         rsp_last_bin_ff  <= cmd.last_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_index   = rsp_bin_index_ff;
   assign rsp_real_part   = rsp_real_part_ff;
   assign rsp_imag_part   = rsp_imag_part_ff;
   assign rsp_magnitude   = rsp_magnitude_ff;
   assign rsp_last_bin    = rsp_last_bin_ff;
   assign status.mac_busy = v1_ff | v2_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

@@ src/centered_direct_dft_unit.sv @@
// Top level of the centered direct DFT block: joins the controller and the
// datapath. Depends on cdd_pkg, cdd_ctrl and cdd_datapath.
//
// Usage: the req channel takes one signed Q1.15 sample per transfer; POINTS
// transfers make a frame. While loading, req_ready is high and one sample is
// taken per cycle while req_valid is high. After the last sample of a frame
// the block computes the bins k = -POINTS/2 .. POINTS/2-1 in order and offers
// each on the rsp channel with its real and imaginary sums, magnitude and a
// last_bin flag. Each bin is accumulated over the frame on the single
// multiply-accumulate unit; then its pipeline drains, the real and imaginary
// sums are squared, the one-bit-per-cycle square root runs, and the result is
// loaded into the output register. The output register holds a finished bin
// while the next one is computed; if rsp_ready stays low, the block waits to
// load the following bin. After the last bin is loaded into the output
// register, req_ready rises again. Synchronous reset clears the load count
// and all control state; no sample of an earlier frame is kept valid, and
// the sample memory is not cleared.
`default_nettype none

module centered_direct_dft_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire signed [cdd_pkg::SAMPLE_W-1:0] req_sample,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [cdd_pkg::BIN_W-1:0]   rsp_bin_index,
   output logic signed [cdd_pkg::REAL_W-1:0]  rsp_real_part,
   output logic signed [cdd_pkg::REAL_W-1:0]  rsp_imag_part,
   output logic        [cdd_pkg::MAG_W-1:0]   rsp_magnitude,
   output logic                               rsp_last_bin
);

   cdd_pkg::cmd_type    cmd;
   cdd_pkg::status_type status;

   cdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cdd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_sample    (req_sample),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_real_part (rsp_real_part),
      .rsp_imag_part (rsp_imag_part),
      .rsp_magnitude (rsp_magnitude),
      .rsp_last_bin  (rsp_last_bin)
   );

   // A new result is loaded only when the held one is gone or leaving.
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending transfer");

   // Squaring starts only after the accumulate pipeline has drained.
   a_sq_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.sq_re |-> !status.mac_busy)
      else $error("squaring began before the accumulators settled");

   // An issued product is tracked by the pipeline in the next cycle.
   a_issue_tracked: assert property (@(posedge clock) disable iff (reset)
      cmd.mac_issue |=> status.mac_busy)
      else $error("issued product not tracked by the pipeline");

   // No sample is taken while a bin is being accumulated.
   a_no_load_in_mac: assert property (@(posedge clock) disable iff (reset)
      cmd.mac_issue |-> !req_ready)
      else $error("sample transfer possible during accumulation");

endmodule

`default_nettype wire

@@ tb/dft_bin_checker.sv @@
`timescale 1ns / 100ps
// Checker for the centered direct DFT block: watches the sample and bin channels,
// predicts every bin of each completed frame and compares the bins field by field.
// Depends on cdd_pkg for the frame size and field widths.

module dft_bin_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire signed [cdd_pkg::SAMPLE_W-1:0] req_sample,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire signed [cdd_pkg::BIN_W-1:0]    rsp_bin_index,
   input  wire signed [cdd_pkg::REAL_W-1:0]   rsp_real_part,
   input  wire signed [cdd_pkg::REAL_W-1:0]   rsp_imag_part,
   input  wire        [cdd_pkg::MAG_W-1:0]    rsp_magnitude,
   input  wire                                rsp_last_bin,
   output int                                 mismatch_count,
   output int                                 bins_pending,
   output int                                 bins_checked,
   output int                                 frames_seen
);

   localparam int WAVE_POINTS = 64;
   localparam int REPORT_LIMIT = 10;
   localparam int QUARTER_WAVE [17] = '{
      0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
      25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768
   };

   typedef struct {
      logic signed [cdd_pkg::BIN_W-1:0]  bin_index;
      logic signed [cdd_pkg::REAL_W-1:0] real_part;
      logic signed [cdd_pkg::REAL_W-1:0] imag_part;
      logic [cdd_pkg::MAG_W-1:0]         magnitude;
      logic                              last_bin;
   } dft_bin_type;

   logic signed [cdd_pkg::SAMPLE_W-1:0] frame_samples [cdd_pkg::POINTS];
   dft_bin_type                         expected_bins [$];
   int                                  fill_count;
   int                                  error_tally;
   int                                  checked_tally;
   int                                  frame_tally;

   function automatic int twiddle_sin(input int j);
      int quad;
      int offset;
      int value;
      quad   = (j >> 4) & 3;
      offset = j & 15;
      if (quad == 1 || quad == 3) begin
         offset = 16 - offset;
      end
      value = QUARTER_WAVE[offset];
      if (quad >= 2) begin
         value = -value;
      end
      if (value > 32767) begin
         value = 32767;
      end
      return value;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned radicand);
      longint unsigned rest;
      longint unsigned root;
      longint unsigned probe;
      rest  = radicand;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rest) begin
         probe = probe >> 2;
      end
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Every bin of the frame now held in frame_samples, lowest k first.
   task automatic predict_frame_bins();
      dft_bin_type bin_result;
      longint      acc_re;
      longint      acc_im;
      longint      re;
      longint      im;
      int          kmod;
      int          wave_idx;
      for (int i = 0; i < cdd_pkg::POINTS; i++) begin
         kmod   = (i + cdd_pkg::POINTS / 2) % cdd_pkg::POINTS;
         acc_re = 0;
         acc_im = 0;
         for (int n = 0; n < cdd_pkg::POINTS; n++) begin
            wave_idx = (((n * kmod) % cdd_pkg::POINTS) *
                        (WAVE_POINTS / cdd_pkg::POINTS)) & 63;
            acc_re += longint'(frame_samples[n]) * twiddle_sin((wave_idx + 16) & 63);
            acc_im -= longint'(frame_samples[n]) * twiddle_sin(wave_idx);
         end
         re = acc_re >>> cdd_pkg::FRAC_BITS;
         im = acc_im >>> cdd_pkg::FRAC_BITS;
         bin_result.bin_index = cdd_pkg::BIN_W'(i - cdd_pkg::POINTS / 2);
         bin_result.real_part = cdd_pkg::REAL_W'(re);
         bin_result.imag_part = cdd_pkg::REAL_W'(im);
         bin_result.magnitude = cdd_pkg::MAG_W'(root_floor(longint'(re * re + im * im)));
         bin_result.last_bin  = (i == cdd_pkg::POINTS - 1);
         expected_bins.push_back(bin_result);
      end
   endtask

   always @(posedge clock) begin
      dft_bin_type wanted;
      if (reset) begin
         fill_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bins.size() == 0) begin
               error_tally++;
               if (error_tally <= REPORT_LIMIT) begin
                  $display("Unexpected bin transfer: k=%0d re=%0d im=%0d mag=%0d last=%0b",
                           rsp_bin_index, rsp_real_part, rsp_imag_part, rsp_magnitude,
                           rsp_last_bin);
               end
            end else begin
               wanted = expected_bins.pop_front();
               checked_tally++;
               if (wanted.bin_index !== rsp_bin_index || wanted.real_part !== rsp_real_part
                   || wanted.imag_part !== rsp_imag_part
                   || wanted.magnitude !== rsp_magnitude
                   || wanted.last_bin !== rsp_last_bin) begin
                  error_tally++;
                  if (error_tally <= REPORT_LIMIT) begin
                     $display("Bin mismatch, expected k=%0d re=%0d im=%0d mag=%0d last=%0b",
                              wanted.bin_index, wanted.real_part, wanted.imag_part,
                              wanted.magnitude, wanted.last_bin);
                     $display("               actual k=%0d re=%0d im=%0d mag=%0d last=%0b",
                              rsp_bin_index, rsp_real_part, rsp_imag_part, rsp_magnitude,
                              rsp_last_bin);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            frame_samples[fill_count] = req_sample;
            if (fill_count == cdd_pkg::POINTS - 1) begin
               fill_count = 0;
               predict_frame_bins();
               frame_tally++;
            end else begin
               fill_count++;
            end
         end
      end
      mismatch_count <= error_tally;
      bins_pending   <= expected_bins.size();
      bins_checked   <= checked_tally;
      frames_seen    <= frame_tally;
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the centered direct DFT testbench: clock, reset, sample stimulus, bin
// receiver with stalls, watchdog and verdict. Depends on cdd_pkg, the block
// centered_direct_dft_unit and the checker dft_bin_checker.

module tb_top;

   localparam int BIN_CYCLES     = cdd_pkg::POINTS + cdd_pkg::SQ_STEPS + 6;
   localparam int FRAME_COUNT    = 4;
   localparam int HOLD_AT_BIN    = 70;
   localparam int HOLD_CYCLES    = 1500;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum int {
      FRAME_NOISE,
      FRAME_FULL_SCALE,
      FRAME_ALTERNATING,
      FRAME_IMPULSE,
      FRAME_SMALL,
      FRAME_CONSTANT
   } frame_kind_type;

   typedef enum int {
      RX_STREAM,
      RX_COIN,
      RX_PERIODIC,
      RX_SPARSE
   } rx_mode_type;

   localparam logic signed [cdd_pkg::SAMPLE_W-1:0] DIRECTED_SAMPLES [16] = '{
      16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh4000,
      16'shC000, 16'sh5555, 16'shAAAA, 16'sh7FFE, 16'sh8001, 16'sh00FF,
      16'shFF00, 16'sh0F0F, 16'shF0F0, 16'sh0100
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [cdd_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [cdd_pkg::BIN_W-1:0]    rsp_bin_index;
   logic signed [cdd_pkg::REAL_W-1:0]   rsp_real_part;
   logic signed [cdd_pkg::REAL_W-1:0]   rsp_imag_part;
   logic [cdd_pkg::MAG_W-1:0]           rsp_magnitude;
   logic                                rsp_last_bin;

   int          mismatch_count;
   int          bins_pending;
   int          bins_checked;
   int          frames_seen;
   int          burst_left = 0;
   int          bins_taken = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   rx_mode_type rx_mode = RX_STREAM;
   int          rx_mode_left = 0;
   int          rx_phase = 0;

   centered_direct_dft_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_index (rsp_bin_index),
      .rsp_real_part (rsp_real_part),
      .rsp_imag_part (rsp_imag_part),
      .rsp_magnitude (rsp_magnitude),
      .rsp_last_bin  (rsp_last_bin)
   );

   dft_bin_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_real_part  (rsp_real_part),
      .rsp_imag_part  (rsp_imag_part),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_last_bin   (rsp_last_bin),
      .mismatch_count (mismatch_count),
      .bins_pending   (bins_pending),
      .bins_checked   (bins_checked),
      .frames_seen    (frames_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one sample, holds it until the transfer and then maybe pauses.
   task automatic offer_sample(input logic signed [cdd_pkg::SAMPLE_W-1:0] value);
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 24);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_frame(input frame_kind_type kind, input bit directed_head);
      logic signed [cdd_pkg::SAMPLE_W-1:0] level;
      logic signed [cdd_pkg::SAMPLE_W-1:0] value;
      int                                  spike_pos;
      level     = cdd_pkg::SAMPLE_W'($urandom());
      spike_pos = $urandom_range(0, cdd_pkg::POINTS - 1);
      if (kind == FRAME_FULL_SCALE) begin
         level = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      for (int n = 0; n < cdd_pkg::POINTS; n++) begin
         case (kind)
            FRAME_FULL_SCALE,
            FRAME_CONSTANT:    value = level;
            FRAME_ALTERNATING: value = n[0] ? 16'sh7FFF : 16'sh8000;
            FRAME_IMPULSE:     value = (n == spike_pos) ? level : '0;
            FRAME_SMALL:       value = cdd_pkg::SAMPLE_W'($signed($urandom_range(0, 15)) - 8);
            default:           value = cdd_pkg::SAMPLE_W'($urandom());
         endcase
         if (directed_head && n < 16) begin
            value = DIRECTED_SAMPLES[n];
         end
         offer_sample(value);
      end
   endtask

   // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         bins_taken <= bins_taken + 1;
      end
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && bins_taken == HOLD_AT_BIN) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rx_phase <= rx_phase + 1;
         if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_type'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(50, 300);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp_ready <= (rx_phase % 4 == 0);
            RX_SPARSE:   rsp_ready <= ($urandom_range(0, 7) == 0);
            default:     rsp_ready <= 1'b1;
         endcase
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Watchdog expired after %0d cycles without a transfer.", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 24);
      send_frame(FRAME_NOISE, 1'b1);
      send_frame(FRAME_FULL_SCALE, 1'b0);
      send_frame(FRAME_ALTERNATING, 1'b0);
      for (int f = 3; f < FRAME_COUNT; f++) begin
         send_frame(frame_kind_type'($urandom_range(0, 5)), 1'b0);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (bins_pending != 0) begin
         @(posedge clock);
      end
      repeat (3 * BIN_CYCLES) @(posedge clock);
      $display("Run covered %0d frames of %0d samples and %0d checked bins.",
               frames_seen, cdd_pkg::POINTS, bins_checked);
      $display("Stimulus: directed extremes, full-scale, alternating and random frames, %s",
               "sender gaps, receiver stalls and one long hold-off.");
      if (mismatch_count == 0 && bins_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d bins still expected.", mismatch_count, bins_pending);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
